/* hw/rtl/sobel_edge_gradient_assert.svh */
// Assertion macros used by the checker file of the Sobel edge gradient block.
`ifndef SOBEL_EDGE_GRADIENT_ASSERT_SVH
`define SOBEL_EDGE_GRADIENT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SOBEL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SOBEL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sobel_pkg.sv */
// Package with widths, register indexes and kernels of the Sobel edge gradient block.
`timescale 1ns / 1ps

package sobel_pkg;

  // Frame size limits and the widths that follow from them.
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int SizeW     = 11;
  localparam int PixW      = 8;
  localparam int GradW     = 11;
  localparam int AccW      = GradW + 1;
  localparam int OutDataW  = ((3 * GradW + 7) / 8) * 8;
  localparam int CfgIdxW   = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1
  } cfg_idx_e;

  // Kernels, row by row from the top-left tap.
  localparam logic signed [2:0] KernX [9] = '{
    -3'sd1, 3'sd0, 3'sd1,
    -3'sd2, 3'sd0, 3'sd2,
    -3'sd1, 3'sd0, 3'sd1
  };
  localparam logic signed [2:0] KernY [9] = '{
    -3'sd1, -3'sd2, -3'sd1,
    3'sd0, 3'sd0, 3'sd0,
    3'sd1, 3'sd2, 3'sd1
  };

  // Weighted sum of a 3x3 window; the taps are independent products.
  function automatic logic signed [AccW-1:0] apply_kernel(
    input logic signed [2:0] kern [9],
    input logic [PixW-1:0] win [9]
  );
    logic signed [AccW-1:0] acc;
    acc = '0;
    for (int t = 0; t < 9; t++) begin
      acc = acc + AccW'(kern[t]) * $signed({{(AccW-PixW){1'b0}}, win[t]});
    end
    return acc;
  endfunction

endpackage

/* hw/rtl/sobel_edge_gradient.sv */
// Top level of the streaming 3x3 Sobel edge gradient block.
// Usage:
//   Pixels enter in raster order on the s_axis channel, one 8-bit grey level
//   per beat. For each pixel one result beat leaves on m_axis: gradient_x,
//   gradient_y and magnitude = |gx| + |gy| of the window whose bottom-right
//   corner is that pixel, i.e. output position (row-1, col-1). tuser carries
//   window_valid; it is low, with zero gradients, until two rows and two
//   columns of the frame have arrived.
//   The cfg channel writes image_width (index 0) and image_height (index 1),
//   clamped to 3..1024; a write to either restarts the frame at row 0, column 0.
//   Throughput is one pixel per clock while the receiver accepts. An accepted
//   beat registers in the read stage together with the line memory reads, and
//   the kernel sums then load the output register that drives m_axis.
//   The two line memories (1024 x 8 each) are read at the accepted column and
//   written back when that pixel moves on; same-column accesses are a full
//   row apart, so no forwarding is needed.
//   Reset clears the position, the window and both sizes to 1024; the line
//   memories keep their contents. When the receiver stalls, the output beat
//   holds and the read stage fills, after which s_axis_tready drops.
`timescale 1ns / 1ps

module sobel_edge_gradient
  import sobel_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Pixel input; tdata: pixel [7:0].
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PixW-1:0]      s_axis_tdata,
  // Gradient output; tdata: gradient_x [10:0], gradient_y [21:11],
  // magnitude [32:22], zero fill above.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,
  // tuser: window_valid [0].
  output logic                 m_axis_tuser,
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [SizeW-1:0]     cfg_data_i
);

  // Frame size, stored already clamped.
  logic [SizeW-1:0] width_q, height_q;
  logic [SizeW-1:0] cfg_clamped;
  logic [SizeW-1:0] cfg_max;

  // Position of the next pixel.
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  // Line memories and their registered read data.
  logic [PixW-1:0] upper_mem  [MaxWidth];
  logic [PixW-1:0] middle_mem [MaxWidth];
  logic [PixW-1:0] rd_up_q, rd_mid_q;

  // Read stage.
  logic            s1_valid_q;
  logic [PixW-1:0] s1_pix_q;
  logic [ColW-1:0] s1_col_q;
  logic            s1_win_ok_q;

  // Two previous columns: entries 0..2 column col-2, 3..5 column col-1.
  logic [PixW-1:0] win_cols_q [6];

  // Output register.
  logic                    out_valid_q;
  logic signed [GradW-1:0] out_gx_q, out_gy_q;
  logic [GradW-1:0]        out_mag_q;
  logic                    out_win_ok_q;

  logic in_acc, s1_go;
  logic [PixW-1:0] win [9];
  logic signed [AccW-1:0] gx, gy, ax, ay;
  logic [AccW-1:0] mag;

  assign cfg_ready_o   = 1'b1;
  assign s1_go         = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Clamp an incoming size to 3 and the limit of its register.
  always_comb begin
    cfg_max = (cfg_index_i == CfgImageHeight) ? SizeW'(MaxHeight) : SizeW'(MaxWidth);
    if (cfg_data_i < SizeW'(3)) begin
      cfg_clamped = SizeW'(3);
    end else if (cfg_data_i > cfg_max) begin
      cfg_clamped = cfg_max;
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(MaxWidth);
      height_q <= SizeW'(MaxHeight);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgImageWidth:  width_q  <= cfg_clamped;
        CfgImageHeight: height_q <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // Raster position advance with wrap at row and frame end.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_valid_i && (cfg_index_i == CfgImageWidth || cfg_index_i == CfgImageHeight)) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if ({1'b0, col_q} + SizeW'(1) >= width_q) begin
        col_d = '0;
        if ({1'b0, row_q} + SizeW'(1) >= height_q) begin
          row_d = '0;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line memories: read at the accepted column, write back as the pixel leaves.
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      upper_mem[s1_col_q]  <= rd_mid_q;
      middle_mem[s1_col_q] <= s1_pix_q;
    end
    if (in_acc) begin
      rd_up_q  <= upper_mem[col_q];
      rd_mid_q <= middle_mem[col_q];
    end
  end

  // Read stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q    <= s_axis_tdata;
      s1_col_q    <= col_q;
      s1_win_ok_q <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
    end
  end

  // Assemble the 3x3 window and apply both kernels.
  always_comb begin
    for (int m = 0; m < 3; m++) begin
      win[m*3]     = win_cols_q[m];
      win[m*3 + 1] = win_cols_q[3 + m];
    end
    win[2] = rd_up_q;
    win[5] = rd_mid_q;
    win[8] = s1_pix_q;
    gx  = apply_kernel(KernX, win);
    gy  = apply_kernel(KernY, win);
    ax  = gx[AccW-1] ? -gx : gx;
    ay  = gy[AccW-1] ? -gy : gy;
    mag = AccW'(ax) + AccW'(ay);
  end

  // Column window shifts as each pixel leaves the read stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        win_cols_q[k] <= '0;
      end
    end else if (s1_go) begin
      for (int k = 0; k < 3; k++) begin
        win_cols_q[k] <= win_cols_q[3 + k];
      end
      win_cols_q[3] <= rd_up_q;
      win_cols_q[4] <= rd_mid_q;
      win_cols_q[5] <= s1_pix_q;
    end
  end

  // Output register; invalid windows give zero results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_win_ok_q <= s1_win_ok_q;
      out_gx_q     <= s1_win_ok_q ? gx[GradW-1:0] : '0;
      out_gy_q     <= s1_win_ok_q ? gy[GradW-1:0] : '0;
      out_mag_q    <= s1_win_ok_q ? mag[GradW-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_win_ok_q;
  assign m_axis_tdata  = {{(OutDataW - 3*GradW){1'b0}}, out_mag_q, out_gy_q, out_gx_q};

endmodule

/* hw/rtl/sobel_checker.sv */
// Port-level checker for the Sobel edge gradient block, with its bind.
`timescale 1ns / 1ps
`include "sobel_edge_gradient_assert.svh"

module sobel_checker
  import sobel_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  logic signed [GradW-1:0] gx, gy;
  logic [GradW-1:0]        mag;
  logic signed [AccW-1:0]  ax, ay;
  logic [AccW-1:0]         abs_sum;
  logic                    gx_in_range;

  // Unpack the result beat and recompute the magnitude from the gradients.
  always_comb begin
    gx          = $signed(m_axis_tdata[GradW-1:0]);
    gy          = $signed(m_axis_tdata[2*GradW-1:GradW]);
    mag         = m_axis_tdata[3*GradW-1:2*GradW];
    ax          = gx[GradW-1] ? -AccW'(gx) : AccW'(gx);
    ay          = gy[GradW-1] ? -AccW'(gy) : AccW'(gy);
    abs_sum     = AccW'(ax) + AccW'(ay);
    gx_in_range = (gx >= -GradW'(1020)) && (gx <= GradW'(1020));
  end

  // A stalled result beat holds its data.
  `SOBEL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                     "result beat changed while stalled")

  // The input is held off only while a result beat waits at the output.
  `SOBEL_ASSERT_NOW(a_in_stall, clk_i, rst_ni, s_axis_tvalid && !s_axis_tready,
                    m_axis_tvalid && !m_axis_tready, "input stalled with output free")

  // An invalid window carries zero gradients and magnitude.
  `SOBEL_ASSERT_NOW(a_invalid_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
                    m_axis_tdata == '0, "invalid window with nonzero result")

  // The magnitude is the sum of the absolute gradients.
  `SOBEL_ASSERT_NOW(a_mag_sum, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                    {1'b0, mag} == abs_sum, "magnitude differs from |gx|+|gy|")

  // The horizontal gradient stays within the reach of 8-bit pixels.
  `SOBEL_ASSERT_NOW(a_gx_range, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                    gx_in_range, "horizontal gradient out of range")

endmodule

bind sobel_edge_gradient sobel_checker u_sobel_checker (.*);
